### rtl/cuh2v2_pkg.sv
// Package for the 2x2 chroma upsampler: register indexes, block types
// and the 9:3:3:1 weighting function. No dependencies.
package cuh2v2_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegChromaWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegChromaHeight = 1'd1;

  localparam logic [12:0] MaxRows = 13'd4096;

  localparam int unsigned NumSlots = 4;

  typedef struct packed {
    logic [7:0] tl;
    logic [7:0] tr;
    logic [7:0] bl;
    logic [7:0] br;
  } quad_t;

  typedef struct packed {
    logic [10:0] col;
    logic [11:0] row;
    quad_t       cb;
    quad_t       cr;
  } blk_t;

  function automatic logic [7:0] weigh(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    logic [11:0] sum;
    sum = 12'(a) * 12'd9 + 12'(b) * 12'd3 + 12'(c) * 12'd3 + 12'(d) + 12'd8;
    return sum[11:4];
  endfunction

endpackage

### rtl/cuh2v2_lane.sv
// One lane: forms a full 2x2 block for both chroma planes from four pairs.
// Depends on cuh2v2_pkg.
module cuh2v2_lane import cuh2v2_pkg::*; (
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  input  logic [15:0] c_i,
  input  logic [15:0] d_i,
  input  logic [10:0] col_i,
  input  logic [11:0] row_i,
  output blk_t        blk_o
);

  // Cb sits in the low byte of each pair and Cr in the high byte.
  assign blk_o.col   = col_i;
  assign blk_o.row   = row_i;
  assign blk_o.cb.tl = weigh(a_i[7:0], b_i[7:0], c_i[7:0], d_i[7:0]);
  assign blk_o.cb.tr = weigh(b_i[7:0], a_i[7:0], d_i[7:0], c_i[7:0]);
  assign blk_o.cb.bl = weigh(c_i[7:0], d_i[7:0], a_i[7:0], b_i[7:0]);
  assign blk_o.cb.br = weigh(d_i[7:0], c_i[7:0], b_i[7:0], a_i[7:0]);
  assign blk_o.cr.tl = weigh(a_i[15:8], b_i[15:8], c_i[15:8], d_i[15:8]);
  assign blk_o.cr.tr = weigh(b_i[15:8], a_i[15:8], d_i[15:8], c_i[15:8]);
  assign blk_o.cr.bl = weigh(c_i[15:8], d_i[15:8], a_i[15:8], b_i[15:8]);
  assign blk_o.cr.br = weigh(d_i[15:8], c_i[15:8], b_i[15:8], a_i[15:8]);

endmodule

### rtl/cuh2v2_merge.sv
// Merge stage: holds the lanes' blocks for one transaction and hands them out
// one per cycle when not stalled, via the output register. Uses cuh2v2_pkg.
module cuh2v2_merge import cuh2v2_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_valid_i,
  input  logic [NumSlots-1:0]       load_mask_i,
  input  blk_t [NumSlots-1:0]       load_blk_i,
  output logic                      load_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output blk_t                      out_blk_o,
  output logic                      out_run_end_o
);

  logic [NumSlots-1:0] mask_q, mask_d, rest;
  blk_t [NumSlots-1:0] slot_q;
  logic                ov_q, ov_d;
  blk_t                oblk_q;
  logic                oend_q;
  blk_t                sel;
  logic                out_free, pop, load;

  assign out_free     = !ov_q || !out_stall_i;
  assign pop          = (mask_q != '0) && out_free;
  assign rest         = mask_q & (mask_q - NumSlots'(1));
  assign load_ready_o = (mask_q == '0) || (pop && (rest == '0));
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    priority if (mask_q[0]) begin
      sel = slot_q[0];
    end else if (mask_q[1]) begin
      sel = slot_q[1];
    end else if (mask_q[2]) begin
      sel = slot_q[2];
    end else begin
      sel = slot_q[3];
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (pop) begin
      mask_d = rest;
    end
    if (load) begin
      mask_d = load_mask_i;
    end
    ov_d = ov_q;
    if (out_free) begin
      ov_d = pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q <= load_blk_i;
    end
    if (pop) begin
      oblk_q <= sel;
      oend_q <= (rest == '0);
    end
  end

  assign out_valid_o   = ov_q;
  assign out_blk_o     = oblk_q;
  assign out_run_end_o = oend_q;

  // A pending block is always followed by a valid output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> ov_q)
    else $error("popped block did not reach the output register");

  // New blocks never overwrite more than the one being handed out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (mask_q == '0) || (pop && (rest == '0)))
    else $error("merge slots overwritten while blocks pending");

  // A stalled output keeps the pending mask unchanged, since nothing loads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0) && !out_free |=> mask_q == $past(mask_q))
    else $error("pending blocks lost during output stall");

endmodule

### rtl/chroma_upsample_h2v2_unit.sv
// Top level of the 2x2 chroma upsampler: position counters, row store,
// lane array and merge stage. Depends on cuh2v2_pkg, cuh2v2_lane, cuh2v2_merge.
//
// The unit takes one Cb/Cr sample pair per cycle in raster order while
// in_stall_o is low and returns 2x2 blocks of both planes weighted 9:3:3:1,
// each block tagged with its source column and row. A transaction yields zero
// to four blocks: the last column of a row and every sample of the last row add
// blocks, and the single output port passes one block per cycle when not
// stalled, so such a transaction stalls the input while its blocks go out.
// Otherwise one transaction is taken every cycle while the output runs. A block
// reaches the output from the transaction that completes it via the sample
// register with row store read, the merge slots and the output register. The
// row store holds one row of pairs, MAX_ROW_SAMPLES deep, and needs no clearing
// after reset. Configuration writes are expected only while the unit is idle.
module chroma_upsample_h2v2_unit import cuh2v2_pkg::*; #(
  parameter int unsigned MAX_ROW_SAMPLES = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          cb_sample_i,
  input  logic [7:0]          cr_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [10:0]         block_col_o,
  output logic [11:0]         block_row_o,
  output logic [7:0]          cb_top_left_o,
  output logic [7:0]          cb_top_right_o,
  output logic [7:0]          cb_bottom_left_o,
  output logic [7:0]          cb_bottom_right_o,
  output logic [7:0]          cr_top_left_o,
  output logic [7:0]          cr_top_right_o,
  output logic [7:0]          cr_bottom_left_o,
  output logic [7:0]          cr_bottom_right_o,
  output logic                run_end_o
);

  localparam int unsigned CW = (MAX_ROW_SAMPLES > 1) ? $clog2(MAX_ROW_SAMPLES) : 1;
  localparam logic [13:0] MaxW = 14'(MAX_ROW_SAMPLES);

  typedef struct packed {
    logic [15:0]   cur;
    logic [CW-1:0] x;
    logic [11:0]   y;
    logic          last_col;
    logic          last_row;
  } s1_t;

  logic [11:0]   width_q;
  logic [12:0]   height_q;
  logic [CW-1:0] col_q, col_d;
  logic [11:0]   row_q, row_d;
  logic [13:0]   w_eff;
  logic [12:0]   h_eff;
  logic          last_col, last_row;
  logic [15:0]   cur;
  logic          in_acc;

  logic [15:0]   row_mem_q [MAX_ROW_SAMPLES];
  logic [15:0]   up_q;

  s1_t           s1_q;
  logic          s1_valid_q, s1_valid_d;
  logic          s1_move;
  logic [15:0]   ul_q, left_q;

  logic                merge_ready;
  logic [NumSlots-1:0] mask;
  blk_t [NumSlots-1:0] blk;
  blk_t                out_blk;
  logic [10:0]         col_cur, col_prev;
  logic [11:0]         row_prev;
  logic                has_up, has_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd1;
      height_q <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegChromaWidth:  width_q  <= cfg_wdata_i[11:0];
        RegChromaHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = 14'(width_q);
    if (w_eff == 14'd0) begin
      w_eff = 14'd1;
    end else if (w_eff > MaxW) begin
      w_eff = MaxW;
    end
    h_eff = height_q;
    if (h_eff == 13'd0) begin
      h_eff = 13'd1;
    end else if (h_eff > MaxRows) begin
      h_eff = MaxRows;
    end
  end

  assign last_col   = (14'(col_q) + 14'd1) >= w_eff;
  assign last_row   = (13'(row_q) + 13'd1) >= h_eff;
  assign cur        = {cr_sample_i, cb_sample_i};
  assign s1_move    = s1_valid_q && merge_ready;
  assign in_stall_o = s1_valid_q && !merge_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? 12'd0 : row_q + 12'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      ul_q       <= '0;
      left_q     <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (s1_move) begin
        ul_q   <= up_q;
        left_q <= s1_q.cur;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_mem_q[col_q] <= cur;
      up_q             <= row_mem_q[col_q];
      s1_q.cur         <= cur;
      s1_q.x           <= col_q;
      s1_q.y           <= row_q;
      s1_q.last_col    <= last_col;
      s1_q.last_row    <= last_row;
    end
  end

  assign has_up   = s1_q.y != 12'd0;
  assign has_left = s1_q.x != '0;
  assign col_cur  = 11'(14'(s1_q.x));
  assign col_prev = 11'(14'(s1_q.x) - 14'd1);
  assign row_prev = s1_q.y - 12'd1;
  assign mask     = {s1_q.last_row && s1_q.last_col, s1_q.last_row && has_left,
                     has_up && s1_q.last_col, has_up && has_left};

  cuh2v2_lane u_lane_diag (
    .a_i(ul_q), .b_i(up_q), .c_i(left_q), .d_i(s1_q.cur),
    .col_i(col_prev), .row_i(row_prev), .blk_o(blk[0])
  );

  cuh2v2_lane u_lane_up (
    .a_i(up_q), .b_i(up_q), .c_i(s1_q.cur), .d_i(s1_q.cur),
    .col_i(col_cur), .row_i(row_prev), .blk_o(blk[1])
  );

  cuh2v2_lane u_lane_left (
    .a_i(left_q), .b_i(s1_q.cur), .c_i(left_q), .d_i(s1_q.cur),
    .col_i(col_prev), .row_i(s1_q.y), .blk_o(blk[2])
  );

  cuh2v2_lane u_lane_corner (
    .a_i(s1_q.cur), .b_i(s1_q.cur), .c_i(s1_q.cur), .d_i(s1_q.cur),
    .col_i(col_cur), .row_i(s1_q.y), .blk_o(blk[3])
  );

  cuh2v2_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid_q),
    .load_mask_i  (mask),
    .load_blk_i   (blk),
    .load_ready_o (merge_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_blk_o    (out_blk),
    .out_run_end_o(run_end_o)
  );

  assign block_col_o       = out_blk.col;
  assign block_row_o       = out_blk.row;
  assign cb_top_left_o     = out_blk.cb.tl;
  assign cb_top_right_o    = out_blk.cb.tr;
  assign cb_bottom_left_o  = out_blk.cb.bl;
  assign cb_bottom_right_o = out_blk.cb.br;
  assign cr_top_left_o     = out_blk.cr.tl;
  assign cr_top_right_o    = out_blk.cr.tr;
  assign cr_bottom_left_o  = out_blk.cr.bl;
  assign cr_bottom_right_o = out_blk.cr.br;

  // The last sample of the image restarts the position at the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_col && last_row |=> (col_q == '0) && (row_q == 12'd0))
    else $error("position did not wrap at end of image");

  // The column counter always addresses an entry of the row store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) 14'(col_q) < MaxW)
    else $error("column counter outside row store");

  // A transaction waiting for the merge stage keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_q) && $stable(up_q))
    else $error("held transaction changed while waiting");

endmodule

### dv/tb_top.sv
// Self-checking testbench for chroma_upsample_h2v2_unit: a queue-fed sample driver, a
// block monitor and an in-line predictor of the 9:3:3:1 upsampler.
// Depends on cuh2v2_pkg and chroma_upsample_h2v2_unit.
module tb_top;
  import cuh2v2_pkg::*;

  localparam int RowSlots = 2048;

  typedef struct packed {
    blk_t blk;
    logic run_end;
  } chroma_block_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = RegChromaWidth;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          cb_sample_i = 8'd0;
  logic [7:0]          cr_sample_i = 8'd0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [10:0]         block_col_o;
  logic [11:0]         block_row_o;
  logic [7:0]          cb_top_left_o;
  logic [7:0]          cb_top_right_o;
  logic [7:0]          cb_bottom_left_o;
  logic [7:0]          cb_bottom_right_o;
  logic [7:0]          cr_top_left_o;
  logic [7:0]          cr_top_right_o;
  logic [7:0]          cr_bottom_left_o;
  logic [7:0]          cr_bottom_right_o;
  logic                run_end_o;

  logic [15:0]   source_pairs[$];
  chroma_block_t pending_blocks[$];
  bit            sample_taken = 1'b0;
  bit            quiet_mode = 1'b0;
  int            holdoff_asked = 0;
  int            holdoff_served = 0;
  int            holdoff_left = 0;
  int            mismatch_count = 0;

  // Mirror of the upsampler state and its registers.
  logic [11:0] width_reg = 12'd1;
  logic [12:0] height_reg = 13'd1;
  logic [15:0] row_pairs[0:RowSlots-1];
  logic [15:0] upper_left = 16'd0;
  logic [15:0] left_pair = 16'd0;
  int          col_count = 0;
  int          row_count = 0;

  chroma_upsample_h2v2_unit #(.MAX_ROW_SAMPLES(RowSlots)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cb_sample_i       (cb_sample_i),
    .cr_sample_i       (cr_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .block_col_o       (block_col_o),
    .block_row_o       (block_row_o),
    .cb_top_left_o     (cb_top_left_o),
    .cb_top_right_o    (cb_top_right_o),
    .cb_bottom_left_o  (cb_bottom_left_o),
    .cb_bottom_right_o (cb_bottom_right_o),
    .cr_top_left_o     (cr_top_left_o),
    .cr_top_right_o    (cr_top_right_o),
    .cr_bottom_left_o  (cr_bottom_left_o),
    .cr_bottom_right_o (cr_bottom_right_o),
    .run_end_o         (run_end_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [7:0] blend(input int a, input int b, input int c, input int d);
    int sum;
    sum = 9 * a + 3 * b + 3 * c + d + 8;
    return 8'(sum >> 4);
  endfunction

  function automatic quad_t weigh_quad(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
    quad_t q;
    q.tl = blend(a, b, c, d);
    q.tr = blend(b, a, d, c);
    q.bl = blend(c, d, a, b);
    q.br = blend(d, c, b, a);
    return q;
  endfunction

  function automatic chroma_block_t build_block(input int col, input int row,
                                                input logic [15:0] a, input logic [15:0] b,
                                                input logic [15:0] c, input logic [15:0] d);
    chroma_block_t result;
    result.blk.col = 11'(col);
    result.blk.row = 12'(row);
    result.blk.cb = weigh_quad(a[7:0], b[7:0], c[7:0], d[7:0]);
    result.blk.cr = weigh_quad(a[15:8], b[15:8], c[15:8], d[15:8]);
    result.run_end = 1'b0;
    return result;
  endfunction

  function automatic void upsample_pair(input logic [7:0] cb, input logic [7:0] cr);
    int            w;
    int            h;
    int            x;
    int            y;
    bit            last_col;
    bit            last_row;
    logic [15:0]   cur;
    logic [15:0]   up;
    chroma_block_t made[$];
    w = (width_reg == 0) ? 1 : (width_reg > RowSlots) ? RowSlots : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > MaxRows) ? int'(MaxRows) : int'(height_reg);
    x = (col_count >= RowSlots) ? RowSlots - 1 : col_count;
    y = row_count;
    last_col = (x + 1 >= w);
    last_row = (y + 1 >= h);
    cur = {cr, cb};
    up = row_pairs[x];
    if (y >= 1) begin
      if (x >= 1) made.push_back(build_block(x - 1, y - 1, upper_left, up, left_pair, cur));
      if (last_col) made.push_back(build_block(x, y - 1, up, up, cur, cur));
    end
    if (last_row) begin
      if (x >= 1) made.push_back(build_block(x - 1, y, left_pair, cur, left_pair, cur));
      if (last_col) made.push_back(build_block(x, y, cur, cur, cur, cur));
    end
    if (made.size() > 0) made[made.size() - 1].run_end = 1'b1;
    foreach (made[i]) pending_blocks.push_back(made[i]);
    row_pairs[x] = cur;
    upper_left = up;
    left_pair = cur;
    if (last_col) begin
      col_count = 0;
      row_count = last_row ? 0 : y + 1;
    end else begin
      col_count = x + 1;
      row_count = y;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic compare_field(input string name, input int got, input int want,
                               input chroma_block_t ref_blk);
    if (got !== want) begin
      flag_mismatch($sformatf("%s of block (%0d,%0d): got %0d, want %0d", name,
                              ref_blk.blk.col, ref_blk.blk.row, got, want));
    end
  endtask

  task automatic check_block(input chroma_block_t got, input chroma_block_t want);
    compare_field("block_col", got.blk.col, want.blk.col, want);
    compare_field("block_row", got.blk.row, want.blk.row, want);
    compare_field("cb_top_left", got.blk.cb.tl, want.blk.cb.tl, want);
    compare_field("cb_top_right", got.blk.cb.tr, want.blk.cb.tr, want);
    compare_field("cb_bottom_left", got.blk.cb.bl, want.blk.cb.bl, want);
    compare_field("cb_bottom_right", got.blk.cb.br, want.blk.cb.br, want);
    compare_field("cr_top_left", got.blk.cr.tl, want.blk.cr.tl, want);
    compare_field("cr_top_right", got.blk.cr.tr, want.blk.cr.tr, want);
    compare_field("cr_bottom_left", got.blk.cr.bl, want.blk.cr.bl, want);
    compare_field("cr_bottom_right", got.blk.cr.br, want.blk.cr.br, want);
    compare_field("run_end", got.run_end, want.run_end, want);
  endtask

  // Sample driver: holds a stalled transaction, otherwise offers the next pair or idles.
  always @(negedge clk_i) begin : feed_samples
    logic [15:0] pair;
    if (!in_valid_i || sample_taken) begin
      if (source_pairs.size() > 0 && (quiet_mode || $urandom_range(99) >= 28)) begin
        pair = source_pairs.pop_front();
        in_valid_i <= 1'b1;
        cb_sample_i <= pair[7:0];
        cr_sample_i <= pair[15:8];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Block receiver: random stalls plus long hold-offs on request.
  always @(negedge clk_i) begin : drain_blocks
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (holdoff_served < holdoff_asked) begin
      holdoff_served++;
      holdoff_left = 95;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_mode && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk_i) begin : watch_ports
    chroma_block_t seen;
    chroma_block_t want;
    if (rst_ni) begin
      sample_taken = in_valid_i && !in_stall_o;
      if (sample_taken) upsample_pair(cb_sample_i, cr_sample_i);
      if (out_valid_o && !out_stall_i) begin
        seen.blk.col = block_col_o;
        seen.blk.row = block_row_o;
        seen.blk.cb = '{cb_top_left_o, cb_top_right_o, cb_bottom_left_o, cb_bottom_right_o};
        seen.blk.cr = '{cr_top_left_o, cr_top_right_o, cr_bottom_left_o, cr_bottom_right_o};
        seen.run_end = run_end_o;
        if (pending_blocks.size() == 0) begin
          flag_mismatch($sformatf("unexpected block (%0d,%0d)", block_col_o, block_row_o));
        end else begin
          want = pending_blocks.pop_front();
          check_block(seen, want);
        end
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk_i);
    while (source_pairs.size() != 0 || in_valid_i || pending_blocks.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] index, input int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = index;
    cfg_wdata_i = CfgDataW'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input int w, input int h);
    wait_idle();
    write_register(RegChromaWidth, w);
    write_register(RegChromaHeight, h);
    width_reg = 12'(w);
    height_reg = 13'(h);
  endtask

  task automatic queue_samples(input int count, input bit extremes);
    logic [7:0] cb;
    logic [7:0] cr;
    repeat (count) begin
      if (extremes) begin
        cb = $urandom_range(1) ? 8'hff : 8'h00;
        cr = $urandom_range(1) ? 8'hff : 8'h00;
      end else begin
        cb = 8'($urandom_range(255));
        cr = 8'($urandom_range(255));
      end
      source_pairs.push_back({cr, cb});
    end
  endtask

  initial begin
    int w;
    int h;
    int n;
    int total;
    foreach (row_pairs[i]) row_pairs[i] = 16'd0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: reset size, corners, degenerate and oversized registers,
    // and width and height changes in the middle of an image.
    source_pairs.push_back({8'h00, 8'hff});
    configure(3, 2);
    queue_samples(6, 1'b1);
    configure(0, 0);
    queue_samples(2, 1'b1);
    configure(4095, 8191);
    queue_samples(5, 1'b0);
    configure(2, 3);
    queue_samples(5, 1'b1);
    configure(2, 8191);
    queue_samples(4, 1'b0);
    configure(2, 1);
    queue_samples(2, 1'b0);

    // One wide row with no idling, then a tall single column under a long hold-off.
    configure(64, 1);
    quiet_mode = 1'b1;
    queue_samples(64, 1'b0);
    wait_idle();
    quiet_mode = 1'b0;
    configure(1, 48);
    queue_samples(48, 1'b0);
    holdoff_asked++;

    total = 0;
    while (total < 260) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(64, 7) : $urandom_range(6, 1);
      h = $urandom_range(5, 1);
      configure(w, h);
      n = w * h * $urandom_range(2, 1);
      if (total + n > 280) n = 280 - total;
      queue_samples(n, $urandom_range(7) == 0);
      if (total == 0) holdoff_asked++;
      total += n;
    end

    do @(posedge clk_i);
    while (source_pairs.size() != 0 || in_valid_i);
    for (int i = 0; i < 5000 && pending_blocks.size() != 0; i++) @(posedge clk_i);
    foreach (pending_blocks[i]) begin
      flag_mismatch($sformatf("block (%0d,%0d) never arrived",
                              pending_blocks[i].blk.col, pending_blocks[i].blk.row));
    end
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
